@@ hdl/bmp24_stream_writer_macros.svh @@
// assertion macros for the bmp24 stream writer checker
// the enclosing scope provides clk and arst_n
`ifndef BMP24_STREAM_WRITER_MACROS_SVH
`define BMP24_STREAM_WRITER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define BMP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bmp24 stream writer check failed");

// next-cycle implication, disabled while in reset
`define BMP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bmp24 stream writer check failed");

`endif

@@ hdl/bmp_pkg.sv @@
// shared types, codes and header constants for the bmp24 stream writer
// no dependencies
package bmp_pkg;

	localparam int CFG_W             = 13;
	localparam int DEF_MAX_DIMENSION = 4096;
	localparam int CMDQ_DEPTH        = 4;
	localparam int CMDQ_PTR_W        = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W        = $clog2(CMDQ_DEPTH + 1);

	// input action codes
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_PIXEL = 1'b1;

	// configuration register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// header layout
	localparam logic [5:0]  HDR_LAST      = 6'd53;
	localparam logic [5:0]  OFS_MAGIC_B   = 6'd0;
	localparam logic [5:0]  OFS_MAGIC_M   = 6'd1;
	localparam logic [5:0]  OFS_FILE_SIZE = 6'd2;
	localparam logic [5:0]  OFS_PIX_OFS   = 6'd10;
	localparam logic [5:0]  OFS_DIB_SIZE  = 6'd14;
	localparam logic [5:0]  OFS_WIDTH     = 6'd18;
	localparam logic [5:0]  OFS_HEIGHT    = 6'd22;
	localparam logic [5:0]  OFS_PLANES    = 6'd26;
	localparam logic [5:0]  OFS_DATA_SIZE = 6'd34;
	localparam logic [5:0]  OFS_XPPM      = 6'd38;
	localparam logic [5:0]  OFS_YPPM      = 6'd42;
	localparam logic [7:0]  MAGIC_B       = 8'h42;
	localparam logic [7:0]  MAGIC_M       = 8'h4D;
	localparam logic [31:0] HDR_BYTES     = 32'h36;
	localparam logic [31:0] DIB_BYTES     = 32'h28;
	localparam logic [15:0] PLANES        = 16'h01;
	localparam logic [15:0] BITS_PER_PIX  = 16'h18;
	localparam logic [31:0] PIX_PER_M     = {16'h0, 8'h0B, 8'h13};

	// pixel byte positions
	localparam logic [5:0] PIX_GREEN_IDX = 6'd1;
	localparam logic [5:0] PIX_RED_IDX   = 6'd2;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_PIXEL = 2'd1,
		CMD_ERROR = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic [1:0] pad;
		logic       frame_end;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_req_t;

	function automatic logic in_word(input logic [5:0] idx, input logic [5:0] base);
		return (idx >= base) && (idx < base + 6'd4);
	endfunction

	function automatic logic [7:0] word_byte(input logic [31:0] word, input logic [5:0] idx,
			input logic [5:0] base);
		logic [1:0] sel;
		sel = 2'(idx - base);
		return word[8*sel +: 8];
	endfunction

	// one byte of the 54-byte file header
	function automatic logic [7:0] hdr_byte(input logic [5:0] idx, input logic [31:0] w,
			input logic [31:0] h, input logic [31:0] data);
		logic [31:0] total_len;
		logic [7:0]  b;
		total_len = data + HDR_BYTES;
		priority if (idx == OFS_MAGIC_B) b = MAGIC_B;
		else if (idx == OFS_MAGIC_M) b = MAGIC_M;
		else if (in_word(idx, OFS_FILE_SIZE)) b = word_byte(total_len, idx, OFS_FILE_SIZE);
		else if (in_word(idx, OFS_PIX_OFS)) b = word_byte(HDR_BYTES, idx, OFS_PIX_OFS);
		else if (in_word(idx, OFS_DIB_SIZE)) b = word_byte(DIB_BYTES, idx, OFS_DIB_SIZE);
		else if (in_word(idx, OFS_WIDTH)) b = word_byte(w, idx, OFS_WIDTH);
		else if (in_word(idx, OFS_HEIGHT)) b = word_byte(h, idx, OFS_HEIGHT);
		else if (in_word(idx, OFS_PLANES))
			b = word_byte({BITS_PER_PIX, PLANES}, idx, OFS_PLANES);
		else if (in_word(idx, OFS_DATA_SIZE)) b = word_byte(data, idx, OFS_DATA_SIZE);
		else if (in_word(idx, OFS_XPPM)) b = word_byte(PIX_PER_M, idx, OFS_XPPM);
		else if (in_word(idx, OFS_YPPM)) b = word_byte(PIX_PER_M, idx, OFS_YPPM);
		else b = 8'h00;
		return b;
	endfunction

endpackage

@@ hdl/bmp_front.sv @@
// front end: accepts items, tracks row and column, classifies each item into a command
// depends on bmp_pkg
module bmp_front #(
	parameter int MAX_DIMENSION = bmp_pkg::DEF_MAX_DIMENSION,
	localparam int DIM_W = $clog2(MAX_DIMENSION + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                q_full,
	input  logic                action,
	input  logic [7:0]          blue,
	input  logic [7:0]          green,
	input  logic [7:0]          red,
	input  logic [DIM_W-1:0]    used_w,
	input  logic [DIM_W-1:0]    used_h,
	output bmp_pkg::cmd_req_t   push
);

	logic [DIM_W-1:0] column_q;
	logic [DIM_W-1:0] row_q;
	logic             active_q;
	logic             accept;
	logic [DIM_W-1:0] col_next;
	logic [DIM_W-1:0] row_next;
	logic             row_end;
	logic             frame_end;

	assign accept    = in_valid && !q_full;
	assign col_next  = column_q + DIM_W'(1);
	assign row_next  = row_q + DIM_W'(1);
	assign row_end   = col_next >= used_w;
	assign frame_end = row_end && (row_next >= used_h);

	always_comb begin
		push.valid         = accept;
		push.cmd.blue      = blue;
		push.cmd.green     = green;
		push.cmd.red       = red;
		push.cmd.pad       = row_end ? used_w[1:0] : 2'd0;
		push.cmd.frame_end = frame_end;
		if (action == bmp_pkg::ACT_START) begin
			push.cmd.kind = bmp_pkg::CMD_START;
		end else if (!active_q) begin
			push.cmd.kind = bmp_pkg::CMD_ERROR;
		end else begin
			push.cmd.kind = bmp_pkg::CMD_PIXEL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
			active_q <= 1'b0;
		end else if (accept) begin
			if (action == bmp_pkg::ACT_START) begin
				column_q <= '0;
				row_q    <= '0;
				active_q <= 1'b1;
			end else if (active_q) begin
				if (frame_end) begin
					column_q <= '0;
					row_q    <= '0;
					active_q <= 1'b0;
				end else if (row_end) begin
					column_q <= '0;
					row_q    <= row_next;
				end else begin
					column_q <= col_next;
				end
			end
		end
	end

endmodule

@@ hdl/bmp_cmdq.sv @@
// short command queue between the front end and the byte emitter
// depends on bmp_pkg
module bmp_cmdq (
	input  logic               clk,
	input  logic               arst_n,
	input  bmp_pkg::cmd_req_t  push,
	input  logic               pop,
	output logic               full,
	output bmp_pkg::cmd_req_t  head
);

	bmp_pkg::cmd_t                    slot_q [bmp_pkg::CMDQ_DEPTH];
	logic [bmp_pkg::CMDQ_PTR_W-1:0]   wr_ptr_q;
	logic [bmp_pkg::CMDQ_PTR_W-1:0]   rd_ptr_q;
	logic [bmp_pkg::CMDQ_CNT_W-1:0]   count_q;
	logic                             do_pop;

	localparam logic [bmp_pkg::CMDQ_PTR_W-1:0] LAST_PTR =
		bmp_pkg::CMDQ_PTR_W'(bmp_pkg::CMDQ_DEPTH - 1);
	localparam logic [bmp_pkg::CMDQ_CNT_W-1:0] FULL_CNT =
		bmp_pkg::CMDQ_CNT_W'(bmp_pkg::CMDQ_DEPTH);

	assign full       = count_q == FULL_CNT;
	assign head.valid = count_q != '0;
	assign head.cmd   = slot_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			slot_q[wr_ptr_q] <= push.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push.valid && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ hdl/bmp_back.sv @@
// back end: expands queued commands into file bytes, one per cycle unless out_stall holds the output register
// depends on bmp_pkg
module bmp_back #(
	parameter int MAX_DIMENSION = bmp_pkg::DEF_MAX_DIMENSION,
	localparam int DIM_W = $clog2(MAX_DIMENSION + 1)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bmp_pkg::cmd_req_t  head,
	output logic               pop,
	input  logic [DIM_W-1:0]   used_w,
	input  logic [DIM_W-1:0]   used_h,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         out_byte,
	output logic               run_last,
	output logic               frame_done,
	output logic               seq_error
);

	localparam int ROW_W  = $clog2(3 * MAX_DIMENSION + 4);
	localparam int PROD_W = ROW_W + DIM_W;

	logic                busy_q;
	bmp_pkg::cmd_kind_t  kind_q;
	logic [5:0]          idx_q;
	logic [7:0]          green_q;
	logic [7:0]          red_q;
	logic [1:0]          pad_q;
	logic                fend_q;
	logic [ROW_W-1:0]    row_bytes_q;
	logic [31:0]         data_q;
	logic [PROD_W-1:0]   prod;

	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                run_last_q;
	logic                frame_done_q;
	logic                seq_error_q;

	logic                advance;
	logic [7:0]          nxt_byte;
	logic                nxt_last;
	logic                nxt_done;
	logic                nxt_err;

	assign advance = !out_valid_q || !out_stall;
	assign pop     = advance && !busy_q && head.valid;
	assign prod    = PROD_W'(row_bytes_q) * PROD_W'(used_h);

	// padded row size and pixel data size follow the registers; they settle well
	// before the header bytes that carry them
	always_ff @(posedge clk) begin
		row_bytes_q <= ROW_W'({used_w, 1'b0}) + ROW_W'(used_w) + ROW_W'(used_w[1:0]);
		data_q      <= 32'(prod);
	end

	always_comb begin
		nxt_byte = 8'h00;
		nxt_last = 1'b0;
		nxt_done = 1'b0;
		nxt_err  = 1'b0;
		if (busy_q) begin
			unique case (kind_q)
				bmp_pkg::CMD_START: begin
					nxt_byte = bmp_pkg::hdr_byte(idx_q, 32'(used_w), 32'(used_h), data_q);
					nxt_last = idx_q == bmp_pkg::HDR_LAST;
				end
				bmp_pkg::CMD_PIXEL: begin
					priority if (idx_q == bmp_pkg::PIX_GREEN_IDX) begin
						nxt_byte = green_q;
					end else if (idx_q == bmp_pkg::PIX_RED_IDX) begin
						nxt_byte = red_q;
						nxt_last = pad_q == 2'd0;
					end else begin
						nxt_last = idx_q == bmp_pkg::PIX_RED_IDX + 6'(pad_q);
					end
					nxt_done = fend_q && nxt_last;
				end
				default: begin
					nxt_last = 1'b1;
					nxt_err  = 1'b1;
				end
			endcase
		end else begin
			unique case (head.cmd.kind)
				bmp_pkg::CMD_START: nxt_byte = bmp_pkg::MAGIC_B;
				bmp_pkg::CMD_PIXEL: nxt_byte = head.cmd.blue;
				default: begin
					nxt_last = 1'b1;
					nxt_err  = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q || head.valid;
			if (busy_q) begin
				if (nxt_last) begin
					busy_q <= 1'b0;
				end
			end else if (head.valid) begin
				busy_q <= head.cmd.kind != bmp_pkg::CMD_ERROR;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q   <= nxt_byte;
			run_last_q   <= nxt_last;
			frame_done_q <= nxt_done;
			seq_error_q  <= nxt_err;
			if (busy_q) begin
				idx_q <= idx_q + 6'd1;
			end else if (head.valid) begin
				kind_q  <= head.cmd.kind;
				idx_q   <= 6'd1;
				green_q <= head.cmd.green;
				red_q   <= head.cmd.red;
				pad_q   <= head.cmd.pad;
				fend_q  <= head.cmd.frame_end;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_last   = run_last_q;
	assign frame_done = frame_done_q;
	assign seq_error  = seq_error_q;

endmodule

@@ hdl/bmp24_stream_writer.sv @@
// top level of the 24-bit bmp byte stream writer: registers, dimension clamp, front, queue, back
// depends on bmp_pkg, bmp_front, bmp_cmdq, bmp_back
//
// Streams a 24-bit uncompressed bmp file one byte per output request. A start
// request (action 0) produces the 54-byte header; a pixel request produces
// blue, green, red, plus 1 to 3 zero pad bytes at the end of a row whose byte
// count is not a multiple of four; a pixel outside an open frame produces one
// error byte. The single byte-wide output register sets the pace: one byte
// leaves per cycle unless out_stall holds it, and a new request starts only
// after the last byte of the previous one. Input requests are taken while the
// 4-entry command queue has room, so the input side keeps moving while the
// output stalls. Width and height of 0 act as 1 and values above MAX_DIMENSION
// act as MAX_DIMENSION; write them only while the block is idle.
module bmp24_stream_writer #(
	parameter int MAX_DIMENSION = bmp_pkg::DEF_MAX_DIMENSION
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [bmp_pkg::CFG_W-1:0] cfg_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic [7:0]                blue,
	input  logic [7:0]                green,
	input  logic [7:0]                red,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                out_byte,
	output logic                      run_last,
	output logic                      frame_done,
	output logic                      seq_error
);

	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);

	logic [bmp_pkg::CFG_W-1:0] image_width_q;
	logic [bmp_pkg::CFG_W-1:0] image_height_q;
	logic [DIM_W-1:0]          used_w;
	logic [DIM_W-1:0]          used_h;
	logic                      q_full;
	logic                      q_pop;
	bmp_pkg::cmd_req_t         q_push;
	bmp_pkg::cmd_req_t         q_head;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [bmp_pkg::CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (32'(v) > 32'(MAX_DIMENSION)) begin
			r = DIM_W'(MAX_DIMENSION);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= bmp_pkg::CFG_W'(1);
			image_height_q <= bmp_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				bmp_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				bmp_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign used_w   = clamp_dim(image_width_q);
	assign used_h   = clamp_dim(image_height_q);
	assign in_stall = q_full;

	bmp_front #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.q_full   (q_full),
		.action   (action),
		.blue     (blue),
		.green    (green),
		.red      (red),
		.used_w   (used_w),
		.used_h   (used_h),
		.push     (q_push)
	);

	bmp_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.pop    (q_pop),
		.full   (q_full),
		.head   (q_head)
	);

	bmp_back #(
		.MAX_DIMENSION(MAX_DIMENSION)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (q_head),
		.pop        (q_pop),
		.used_w     (used_w),
		.used_h     (used_h),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.frame_done (frame_done),
		.seq_error  (seq_error)
	);

endmodule

@@ hdl/bmp_checker.sv @@
// port-level checks for the bmp24 stream writer, bound to the top level
// depends on bmp24_stream_writer_macros.svh and bmp24_stream_writer
`include "bmp24_stream_writer_macros.svh"

module bmp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       frame_done,
	input logic       seq_error
);

	// an error request is a lone zero byte that ends its run but never a frame
	`BMP_ASSERT_IMP(a_err_byte, out_valid && seq_error, out_byte == 8'h00 && run_last && !frame_done)

	// the final byte of a file always closes the run of its pixel
	`BMP_ASSERT_IMP(a_done_last, out_valid && frame_done, run_last && !seq_error)

	// a stalled output byte stays put
	`BMP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(run_last))

endmodule

bind bmp24_stream_writer bmp_checker u_bmp_checker (.*);
